// ----- src/b58_pkg.sv -----
// Package for the base58 encoder: transaction payload types, sequencer states,
// and the alphabet lookup. No dependencies.
package b58_pkg;

  localparam int unsigned RESULT_CAP = 44;
  localparam int unsigned KW         = 6;
  localparam int unsigned TOT_W      = 8;
  localparam logic [6:0]  CHAR_ONE   = 7'd49;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_char;
    logic       too_long;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD,
    ST_APPEND,
    ST_TRIM_RD,
    ST_TRIM_CHK,
    ST_EMIT_PRE,
    ST_EMIT
  } state_e;

  function automatic logic [6:0] b58_symbol(input logic [5:0] digit);
    logic [6:0] d;
    logic [6:0] ch;
    d = (digit >= 6'd58) ? 7'(digit - 6'd58) : {1'b0, digit};
    if (d < 7'd9) begin
      ch = 7'd49 + d;
    end else if (d < 7'd17) begin
      ch = 7'd65 + (d - 7'd9);
    end else if (d < 7'd22) begin
      ch = 7'd74 + (d - 7'd17);
    end else if (d < 7'd33) begin
      ch = 7'd80 + (d - 7'd22);
    end else if (d < 7'd44) begin
      ch = 7'd97 + (d - 7'd33);
    end else begin
      ch = 7'd109 + (d - 7'd44);
    end
    return ch;
  endfunction

endpackage

// ----- src/b58_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module b58_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 44
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/b58_divmod.sv -----
// Shared divide-by-58 unit: quotient by reciprocal multiply, remainder by
// back-multiply. Exact for inputs below 57*256+256. No dependencies.
module b58_divmod (
  input  logic [13:0] value_i,
  output logic [7:0]  quot_o,
  output logic [5:0]  rem_o
);

  logic [24:0] prod;
  logic [13:0] back;

  assign prod   = 25'(value_i) * 25'd1130;
  assign quot_o = prod[23:16];
  assign back   = 14'(quot_o) * 14'd58;
  assign rem_o  = 6'(value_i - back);

endmodule

// ----- src/base58_encoder.sv -----
// Base58 encoder top level: sequencer, digit store and shared divide-by-58 unit.
// After a byte is accepted, busy stays high while it is folded into the stored digits and
// new digits are appended; leading zero and dropped bytes leave it low unless they are final.
// On the final byte, after the append, any trim and the ST_EMIT_PRE read, results appear
// one per cycle, 44 at most, and busy falls with the last one. The receiver cannot stall.
// Asynchronous active-low reset clears all control state; the digit store is not cleared.
module base58_encoder
  import b58_pkg::*;
#(
  parameter int unsigned MAX_BYTES  = 32,
  parameter int unsigned MAX_DIGITS = 44
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  in_i,
  output logic strobe_o,
  output out_t out_o
);

  localparam int unsigned AW = $clog2(MAX_DIGITS);
  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned ZW = $clog2(MAX_BYTES + 1);

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [ZW-1:0]   zero_run_q, zero_run_d;
  logic [ZW-1:0]   byte_cnt_q, byte_cnt_d;
  logic            seen_q, seen_d;
  logic            ovf_q, ovf_d;
  logic            last_q, last_d;
  logic [7:0]      carry_q, carry_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [AW-1:0]   didx_q, didx_d;
  logic [KW-1:0]   k_q, k_d;
  logic            strobe_q, strobe_d;
  out_t            out_q, out_d;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [5:0]      wdata;
  logic [AW-1:0]   raddr;
  logic [5:0]      rdata;
  logic [13:0]     dm_value;
  logic [7:0]      dm_quot;
  logic [5:0]      dm_rem;
  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] n_out;
  logic            is_zero;

  b58_ram #(
    .WIDTH(6),
    .DEPTH(MAX_DIGITS)
  ) u_digits (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  b58_divmod u_divmod (
    .value_i(dm_value),
    .quot_o (dm_quot),
    .rem_o  (dm_rem)
  );

  assign busy     = (state_q != ST_IDLE);
  assign strobe_o = strobe_q;
  assign out_o    = out_q;

  assign dm_value = (state_q == ST_FOLD) ? ({rdata, 8'h00} + 14'(carry_q)) : 14'(carry_q);
  assign total    = TOT_W'(zero_run_q) + TOT_W'(count_q);
  assign n_out    = (total > TOT_W'(RESULT_CAP)) ? TOT_W'(RESULT_CAP) : total;
  assign is_zero  = TOT_W'(k_q) < TOT_W'(zero_run_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      zero_run_q <= '0;
      byte_cnt_q <= '0;
      seen_q     <= 1'b0;
      ovf_q      <= 1'b0;
      last_q     <= 1'b0;
      carry_q    <= '0;
      idx_q      <= '0;
      didx_q     <= '0;
      k_q        <= '0;
      strobe_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      zero_run_q <= zero_run_d;
      byte_cnt_q <= byte_cnt_d;
      seen_q     <= seen_d;
      ovf_q      <= ovf_d;
      last_q     <= last_d;
      carry_q    <= carry_d;
      idx_q      <= idx_d;
      didx_q     <= didx_d;
      k_q        <= k_d;
      strobe_q   <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    zero_run_d = zero_run_q;
    byte_cnt_d = byte_cnt_q;
    seen_d     = seen_q;
    ovf_d      = ovf_q;
    last_d     = last_q;
    carry_d    = carry_q;
    idx_d      = idx_q;
    didx_d     = didx_q;
    k_d        = k_q;
    strobe_d   = 1'b0;
    out_d      = out_q;
    we         = 1'b0;
    waddr      = '0;
    wdata      = dm_rem;
    raddr      = '0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          last_d = in_i.last_byte;
          if (byte_cnt_q >= ZW'(MAX_BYTES)) begin
            ovf_d   = 1'b1;
            state_d = in_i.last_byte ? ST_EMIT_PRE : ST_IDLE;
          end else begin
            byte_cnt_d = byte_cnt_q + 1'b1;
            if (!seen_q && (in_i.data_byte == 8'h00)) begin
              zero_run_d = zero_run_q + 1'b1;
              state_d    = in_i.last_byte ? ST_EMIT_PRE : ST_IDLE;
            end else begin
              seen_d  = 1'b1;
              carry_d = in_i.data_byte;
              idx_d   = '0;
              state_d = (count_q != '0) ? ST_FOLD : ST_APPEND;
            end
          end
        end
      end

      ST_FOLD: begin
        we      = 1'b1;
        waddr   = idx_q;
        carry_d = dm_quot;
        raddr   = AW'(idx_q + 1'b1);
        idx_d   = AW'(idx_q + 1'b1);
        if (CW'(idx_q) + 1'b1 == count_q) begin
          state_d = ST_APPEND;
        end
      end

      ST_APPEND: begin
        if (carry_q != '0) begin
          if (count_q < CW'(MAX_DIGITS)) begin
            we      = 1'b1;
            waddr   = AW'(count_q);
            carry_d = dm_quot;
            count_d = count_q + 1'b1;
          end else begin
            ovf_d   = 1'b1;
            state_d = ST_TRIM_RD;
          end
        end else begin
          state_d = last_q ? ST_EMIT_PRE : ST_IDLE;
        end
      end

      ST_TRIM_RD: begin
        raddr = AW'(count_q - 1'b1);
        if (count_q == '0) begin
          state_d = last_q ? ST_EMIT_PRE : ST_IDLE;
        end else begin
          state_d = ST_TRIM_CHK;
        end
      end

      ST_TRIM_CHK: begin
        if (rdata == '0) begin
          count_d = count_q - 1'b1;
          state_d = ST_TRIM_RD;
        end else begin
          state_d = last_q ? ST_EMIT_PRE : ST_IDLE;
        end
      end

      ST_EMIT_PRE: begin
        raddr  = AW'(count_q - 1'b1);
        didx_d = AW'(count_q - 1'b1);
        k_d    = '0;
        if (n_out == '0) begin
          count_d    = '0;
          zero_run_d = '0;
          byte_cnt_d = '0;
          seen_d     = 1'b0;
          ovf_d      = 1'b0;
          state_d    = ST_IDLE;
        end else begin
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        didx_d          = is_zero ? didx_q : AW'(didx_q - 1'b1);
        raddr           = didx_d;
        strobe_d        = 1'b1;
        out_d.out_char  = is_zero ? CHAR_ONE : b58_symbol(rdata);
        out_d.last_char = (TOT_W'(k_q) + 1'b1 == n_out);
        out_d.too_long  = ovf_q;
        k_d             = KW'(k_q + 1'b1);
        if (TOT_W'(k_q) + 1'b1 == n_out) begin
          count_d    = '0;
          zero_run_d = '0;
          byte_cnt_d = '0;
          seen_d     = 1'b0;
          ovf_d      = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
